### rtl/core/rkbm_pkg.sv
// Shared widths, register indexes and saturation for the Redlich-Kister mixing block.
package rkbm_pkg;

  localparam int IN_W       = 16;
  localparam int CFG_W      = 32;
  localparam int OUT_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 50;
  localparam int PIPE_DEPTH = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_L0 = 2'd0,
    COEF_L1 = 2'd1,
    COEF_L2 = 2'd2,
    COEF_L3 = 2'd3
  } coef_idx_t;

  typedef logic signed [CFG_W-1:0] coef_t;
  typedef logic signed [OUT_W-1:0] result_t;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  function automatic result_t sat_out(input logic signed [SUM_W-1:0] x);
    result_t y;
    if (x > SAT_MAX) begin
      y = SAT_MAX[OUT_W-1:0];
    end else if (x < SAT_MIN) begin
      y = SAT_MIN[OUT_W-1:0];
    end else begin
      y = x[OUT_W-1:0];
    end
    return y;
  endfunction

endpackage

### rtl/core/redlich_kister_binary_mixing.sv
// Top level: pipelined third-order Redlich-Kister mixing energy with first and second derivatives.
// The block takes one concentration beat per cycle while in_ready is high and presents the
// excess mixing energy, its slope and its curvature on the outputs from the stage 10 register, where
// each result beat is held until the output side takes it with out_ready. The latency is set
// by the Horner chain of three dependent multiply-and-round steps that build S, followed by the
// split wide products against c(1-c) and the final rounding and saturation, each with a register
// stage of its own. Every stage holds one beat and moves on as soon as the next stage frees up,
// so a stalled output fills the pipe before in_ready drops. Concentrations above one are clamped
// to one; results are rounded to nearest with ties away from zero and saturate to 48 bits. The
// four coefficients are written through the cfg port and must only change while the pipe is empty.
module redlich_kister_binary_mixing #(
  parameter int CONC_FRAC_BITS = 15
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [rkbm_pkg::IN_W-1:0]               in_concentration,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [rkbm_pkg::OUT_W-1:0]       out_mix_energy,
  output logic signed [rkbm_pkg::OUT_W-1:0]       out_mix_slope,
  output logic signed [rkbm_pkg::OUT_W-1:0]       out_mix_curvature,
  input  logic                                    cfg_we,
  input  logic [rkbm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rkbm_pkg::CFG_W-1:0]              cfg_wdata
);
  import rkbm_pkg::*;

  localparam int F   = CONC_FRAC_BITS;
  localparam int CW  = F + 1;
  localparam int CIW = (IN_W > CW) ? IN_W : CW;
  localparam int TW  = F + 2;
  localparam int WW  = 2 * F - 1;
  localparam int VW  = 38;
  localparam int PAW = CFG_W + TW;
  localparam int PBW = VW + TW;
  localparam int PLW = VW + F + 1;
  localparam int PHW = VW + F;
  localparam int PWW = VW + WW + 1;
  localparam int RW  = 2 * F + 40;
  localparam int TRW = 44;

  localparam logic [CIW-1:0] ONE_IN = CIW'(1) << F;
  localparam logic [CW-1:0]  ONE_C  = CW'(1) << F;

  function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] p,
                                               input int sh);
    logic signed [RW-1:0] half;
    logic signed [RW-1:0] sum;
    half = RW'(1) <<< (sh - 1);
    sum  = p + half - $signed({{(RW-1){1'b0}}, p[RW-1]});
    return sum >>> sh;
  endfunction

  localparam int NUM_COEF_SLOTS = 4;
  coef_t coef_r [NUM_COEF_SLOTS];

  logic [PIPE_DEPTH-1:0] v_r;
  logic [PIPE_DEPTH-1:0] v_nxt;
  logic [PIPE_DEPTH-1:0] en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF_SLOTS; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        COEF_L0: coef_r[COEF_L0] <= $signed(cfg_wdata);
        COEF_L1: coef_r[COEF_L1] <= $signed(cfg_wdata);
        COEF_L2: coef_r[COEF_L2] <= $signed(cfg_wdata);
        COEF_L3: coef_r[COEF_L3] <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[PIPE_DEPTH-1] = !v_r[PIPE_DEPTH-1] || out_ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[PIPE_DEPTH-1];

  // stage 0: clamp and form t = 2c - 1
  logic [CIW-1:0]        conc_ext;
  logic [CIW-1:0]        conc_clamp;
  logic [CW-1:0]         c_in;
  logic signed [TW:0]    t_full;
  logic [CW-1:0]         c0_r;
  logic signed [TW-1:0]  t0_r;

  always_comb begin
    conc_ext   = CIW'(in_concentration);
    conc_clamp = (conc_ext > ONE_IN) ? ONE_IN : conc_ext;
    c_in       = conc_clamp[CW-1:0];
    t_full     = $signed({1'b0, c_in, 1'b0}) - $signed({3'b001, {F{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c0_r <= c_in;
      t0_r <= t_full[TW-1:0];
    end
  end

  // stage 1: w = c(1-c), L3 t
  logic [CW-1:0]         one_minus_c;
  logic [2*CW-1:0]       w_full;
  logic signed [TW-1:0]  t1_r;
  logic [WW-1:0]         w1_r;
  logic signed [PAW-1:0] pa1_r;

  always_comb begin
    one_minus_c = ONE_C - c0_r;
    w_full      = c0_r * one_minus_c;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t1_r  <= t0_r;
      w1_r  <= w_full[WW-1:0];
      pa1_r <= PAW'(coef_r[COEF_L3]) * PAW'(t0_r);
    end
  end

  // stage 2: first Horner terms of S, D and all of E
  logic signed [RW-1:0]  pa_e;
  logic signed [TW-1:0]  t2_r;
  logic [WW-1:0]         w2_r;
  logic signed [VW-1:0]  hs2_r;
  logic signed [VW-1:0]  hd2_r;
  logic signed [VW-1:0]  e2_r;

  assign pa_e = RW'(pa1_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t2_r  <= t1_r;
      w2_r  <= w1_r;
      hs2_r <= VW'(coef_r[COEF_L2]) + VW'(rnd(pa_e, F));
      hd2_r <= (VW'(coef_r[COEF_L2]) <<< 1) + VW'(rnd(pa_e + (pa_e <<< 1), F));
      e2_r  <= (VW'(coef_r[COEF_L2]) <<< 1) + VW'(rnd((pa_e <<< 1) + (pa_e <<< 2), F));
    end
  end

  // stage 3
  logic signed [TW-1:0]  t3_r;
  logic [WW-1:0]         w3_r;
  logic signed [VW-1:0]  e3_r;
  logic signed [PBW-1:0] pb3_r;
  logic signed [PBW-1:0] pd3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      t3_r  <= t2_r;
      w3_r  <= w2_r;
      e3_r  <= e2_r;
      pb3_r <= PBW'(hs2_r) * PBW'(t2_r);
      pd3_r <= PBW'(hd2_r) * PBW'(t2_r);
    end
  end

  // stage 4
  logic signed [TW-1:0]  t4_r;
  logic [WW-1:0]         w4_r;
  logic signed [VW-1:0]  e4_r;
  logic signed [VW-1:0]  hs4_r;
  logic signed [VW-1:0]  d4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      t4_r  <= t3_r;
      w4_r  <= w3_r;
      e4_r  <= e3_r;
      hs4_r <= VW'(coef_r[COEF_L1]) + VW'(rnd(RW'(pb3_r), F));
      d4_r  <= VW'(coef_r[COEF_L1]) + VW'(rnd(RW'(pd3_r), F));
    end
  end

  // stage 5
  logic signed [TW-1:0]  t5_r;
  logic [WW-1:0]         w5_r;
  logic signed [VW-1:0]  e5_r;
  logic signed [VW-1:0]  d5_r;
  logic signed [PBW-1:0] pc5_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      t5_r  <= t4_r;
      w5_r  <= w4_r;
      e5_r  <= e4_r;
      d5_r  <= d4_r;
      pc5_r <= PBW'(hs4_r) * PBW'(t4_r);
    end
  end

  // stage 6: S complete
  logic signed [TW-1:0]  t6_r;
  logic [WW-1:0]         w6_r;
  logic signed [VW-1:0]  e6_r;
  logic signed [VW-1:0]  d6_r;
  logic signed [VW-1:0]  s6_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      t6_r <= t5_r;
      w6_r <= w5_r;
      e6_r <= e5_r;
      d6_r <= d5_r;
      s6_r <= VW'(coef_r[COEF_L0]) + VW'(rnd(RW'(pc5_r), F));
    end
  end

  // stage 7: partial products against the low and high halves of w, and t times S and D
  logic signed [F:0]     w_lo;
  logic signed [F-1:0]   w_hi;
  logic signed [PLW-1:0] psl7_r, pdl7_r, pel7_r;
  logic signed [PHW-1:0] psh7_r, pdh7_r, peh7_r;
  logic signed [PBW-1:0] pts7_r, ptd7_r;
  logic signed [VW-1:0]  s7_r;

  assign w_lo = $signed({1'b0, w6_r[F-1:0]});
  assign w_hi = $signed({1'b0, w6_r[WW-1:F]});

  always_ff @(posedge clk) begin
    if (en[7]) begin
      psl7_r <= PLW'(s6_r) * PLW'(w_lo);
      pdl7_r <= PLW'(d6_r) * PLW'(w_lo);
      pel7_r <= PLW'(e6_r) * PLW'(w_lo);
      psh7_r <= PHW'(s6_r) * PHW'(w_hi);
      pdh7_r <= PHW'(d6_r) * PHW'(w_hi);
      peh7_r <= PHW'(e6_r) * PHW'(w_hi);
      pts7_r <= PBW'(t6_r) * PBW'(s6_r);
      ptd7_r <= PBW'(t6_r) * PBW'(d6_r);
      s7_r   <= s6_r;
    end
  end

  // stage 8: combine the halves
  logic signed [PWW-1:0] pws8_r, pwd8_r, pwe8_r;
  logic signed [PBW-1:0] pts8_r, ptd8_r;
  logic signed [VW-1:0]  s8_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      pws8_r <= PWW'(psl7_r) + (PWW'(psh7_r) <<< F);
      pwd8_r <= PWW'(pdl7_r) + (PWW'(pdh7_r) <<< F);
      pwe8_r <= PWW'(pel7_r) + (PWW'(peh7_r) <<< F);
      pts8_r <= pts7_r;
      ptd8_r <= ptd7_r;
      s8_r   <= s7_r;
    end
  end

  // stage 9: round every term
  logic signed [TRW-1:0] ws9_r, wd9_r, we9_r, ts9_r, td9_r;
  logic signed [VW-1:0]  s9_r;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      ws9_r <= TRW'(rnd(RW'(pws8_r), 2 * F));
      wd9_r <= TRW'(rnd(RW'(pwd8_r), 2 * F - 1));
      we9_r <= TRW'(rnd(RW'(pwe8_r), 2 * F - 2));
      ts9_r <= TRW'(rnd(RW'(pts8_r), F));
      td9_r <= TRW'(rnd(RW'(ptd8_r), F - 2));
      s9_r  <= s8_r;
    end
  end

  // stage 10: sum, saturate, hold for the output handshake
  logic signed [SUM_W-1:0] energy_sum, slope_sum, curv_sum;
  result_t energy10_r, slope10_r, curv10_r;

  always_comb begin
    energy_sum = SUM_W'(ws9_r);
    slope_sum  = SUM_W'(wd9_r) - SUM_W'(ts9_r);
    curv_sum   = SUM_W'(we9_r) - SUM_W'(td9_r) - (SUM_W'(s9_r) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      energy10_r <= sat_out(energy_sum);
      slope10_r  <= sat_out(slope_sum);
      curv10_r   <= sat_out(curv_sum);
    end
  end

  assign out_mix_energy    = energy10_r;
  assign out_mix_slope     = slope10_r;
  assign out_mix_curvature = curv10_r;

`ifndef SYNTH
  a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> $countones(v_r) == $past($countones(v_r)) + $past(in_valid && in_ready)
                                 - $past(out_valid && out_ready))
    else $error("pipeline beat count mismatch");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r) && !out_ready)
    else $error("input blocked while the pipe has a free stage");

  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> c0_r <= ONE_C)
    else $error("concentration above one reached the pipe");
`endif

endmodule

### tb/tb_top.sv
// Self-checking bench for the third-order Redlich-Kister mixing pipeline: random and directed beats.
`timescale 1ns / 100ps

module tb_top;
  import rkbm_pkg::*;

  localparam int FRAC       = 15;
  localparam int CYCLE_CAP  = 500000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_BEATS = 165;

  typedef struct {
    logic [IN_W-1:0] conc;
    int              gap;
  } conc_beat_t;

  typedef struct {
    result_t energy;
    result_t slope;
    result_t curvature;
  } mix_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [IN_W-1:0]       in_concentration = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  result_t               out_mix_energy;
  result_t               out_mix_slope;
  result_t               out_mix_curvature;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  conc_beat_t  pending_beats[$];
  mix_result_t mix_expected[$];
  mix_result_t oldest;
  coef_t       coef_model[4];
  int          gap_left;
  int          stall_left;
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          quiet_in;
  bit          quiet_out;

  redlich_kister_binary_mixing #(
    .CONC_FRAC_BITS(FRAC)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_concentration  (in_concentration),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mix_energy    (out_mix_energy),
    .out_mix_slope     (out_mix_slope),
    .out_mix_curvature (out_mix_curvature),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint rnd_mul(input longint a, input longint b, input int sh);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] p;
    logic [63:0]  q;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'd0, ma} * {64'd0, mb};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'h4000_0000_0000_0000) begin
      p = 128'h4000_0000_0000_0000;
    end
    q = p[63:0];
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic result_t clip48(input longint x);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (OUT_W - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      x = hi;
    end else if (x < lo) begin
      x = lo;
    end
    return result_t'(x[OUT_W-1:0]);
  endfunction

  function automatic mix_result_t predict_mix(input logic [IN_W-1:0] conc);
    longint      one;
    longint      cc;
    longint      t;
    longint      w;
    longint      l0, l1, l2, l3;
    longint      h, s, d, e;
    mix_result_t r;
    one = longint'(1) <<< FRAC;
    cc = longint'(conc);
    if (cc > one) begin
      cc = one;
    end
    t = 2 * cc - one;
    w = cc * (one - cc);
    l0 = coef_model[COEF_L0];
    l1 = coef_model[COEF_L1];
    l2 = coef_model[COEF_L2];
    l3 = coef_model[COEF_L3];
    h = l2 + rnd_mul(l3, t, FRAC);
    h = l1 + rnd_mul(h, t, FRAC);
    s = l0 + rnd_mul(h, t, FRAC);
    h = 2 * l2 + rnd_mul(3 * l3, t, FRAC);
    d = l1 + rnd_mul(h, t, FRAC);
    e = 2 * l2 + rnd_mul(6 * l3, t, FRAC);
    r.energy = clip48(rnd_mul(w, s, 2 * FRAC));
    r.slope = clip48(rnd_mul(w, d, 2 * FRAC - 1) - rnd_mul(t, s, FRAC));
    r.curvature = clip48(-2 * s - rnd_mul(t, d, FRAC - 2) + rnd_mul(w, e, 2 * FRAC - 2));
    return r;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [IN_W-1:0] rand_conc();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return IN_W'($urandom_range(0, 32768));
    end else if (r < 88) begin
      case ($urandom_range(0, 4))
        0: return IN_W'(0);
        1: return IN_W'(1);
        2: return IN_W'(16384);
        3: return IN_W'(32767);
        default: return IN_W'(32768);
      endcase
    end
    return IN_W'($urandom_range(32769, 65535));
  endfunction

  function automatic coef_t rand_coef(input int mode);
    case (mode)
      0: return coef_t'($urandom_range(0, 131072)) - coef_t'(65536);
      1: return coef_t'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input result_t want,
                                      input result_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_conc(input logic [IN_W-1:0] conc);
    conc_beat_t b;
    b.conc = conc;
    b.gap = quiet_in ? 0 : draw_gap();
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || mix_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_coef(input coef_idx_t idx, input coef_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    coef_model[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_coefs(input coef_t c0, input coef_t c1, input coef_t c2, input coef_t c3);
    write_coef(COEF_L0, c0);
    write_coef(COEF_L1, c1);
    write_coef(COEF_L2, c2);
    write_coef(COEF_L3, c3);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        mix_expected.insert(mix_expected.size(), predict_mix(in_concentration));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_beats.size() != 0) begin
          in_valid <= 1'b1;
          in_concentration <= pending_beats[0].conc;
          gap_left <= pending_beats[0].gap;
          void'(pending_beats.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (mix_expected.size() == 0) begin
          $error("result beat with nothing outstanding: energy %0d", out_mix_energy);
          mismatches++;
        end else begin
          oldest = mix_expected.pop_front();
          check_field("mix_energy", oldest.energy, out_mix_energy);
          check_field("mix_slope", oldest.slope, out_mix_slope);
          check_field("mix_curvature", oldest.curvature, out_mix_curvature);
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        stall_left <= quiet_out ? 0 : draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int ph;
    int n;
    int mode;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    for (int i = 0; i < 4; i++) begin
      coef_model[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_conc(IN_W'(0));
    push_conc(IN_W'(16384));
    push_conc(IN_W'(32768));
    push_conc(IN_W'(65535));
    push_conc(IN_W'(12345));
    wait_drained();

    set_coefs(32'sd5120, -32'sd2560, 32'sd768, -32'sd1280);
    push_conc(IN_W'(0));
    push_conc(IN_W'(1));
    push_conc(IN_W'(2));
    push_conc(IN_W'(8192));
    push_conc(IN_W'(16383));
    push_conc(IN_W'(16384));
    push_conc(IN_W'(16385));
    push_conc(IN_W'(21845));
    push_conc(IN_W'(24576));
    push_conc(IN_W'(32767));
    push_conc(IN_W'(32768));
    push_conc(IN_W'(32769));
    push_conc(IN_W'(43690));
    push_conc(IN_W'(65535));
    wait_drained();

    set_coefs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_conc(IN_W'(1));
    push_conc(IN_W'(16391));
    push_conc(IN_W'(32768));
    wait_drained();
    set_coefs(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    push_conc(IN_W'(1));
    push_conc(IN_W'(16391));
    push_conc(IN_W'(32768));
    wait_drained();
    set_coefs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    push_conc(IN_W'(1));
    push_conc(IN_W'(16391));
    push_conc(IN_W'(32768));
    wait_drained();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      mode = ph % 3;
      set_coefs(rand_coef(mode), rand_coef(mode), rand_coef(mode), rand_coef(mode));
      quiet_in = (ph % 3 == 0);
      quiet_out = (ph % 4 == 1);
      for (n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 3 && n == PHASE_BEATS / 2) begin
          wait_drained();
        end
        push_conc(rand_conc());
      end
      wait_drained();
    end

    quiet_in = 1'b0;
    quiet_out = 1'b0;
    wait_drained();
    repeat (3 * PIPE_DEPTH) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/rkbm_pkg.sv
rtl/core/redlich_kister_binary_mixing.sv
tb/tb_top.sv
